>>> sv/id3w_pkg.sv
// ----------------------------------------------------------------------------
// id3w_pkg: shared types and constants of the ID3 tag frame walker
// Item structs, result kinds, parse phases, register indexes and header
// constants used by every module of the walker.
// ----------------------------------------------------------------------------
package id3w_pkg;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register reset values
  localparam logic [31:0] STOP_ID_RESET   = 32'h4150_4943;  // "APIC"
  localparam logic [7:0]  MAJOR_VER_RESET = 8'd3;

  // Header positions (tag header bytes 0..9, frame header bytes 0..10)
  localparam logic [3:0] VER_IDX        = 4'd3;
  localparam logic [3:0] REV_IDX        = 4'd4;
  localparam logic [3:0] SIZE_FIRST_IDX = 4'd6;
  localparam logic [3:0] TAG_LAST_IDX   = 4'd9;
  localparam logic [3:0] ID_LAST_IDX    = 4'd3;
  localparam logic [3:0] FSIZE_LAST_IDX = 4'd7;
  localparam logic [3:0] SHIFT_END_IDX  = 4'd8;
  localparam logic [3:0] FRAME_LAST_IDX = 4'd10;
  localparam logic [7:0] REV_BYTE       = 8'd0;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_FRAME_START = 3'd0,
    KIND_TEXT_BYTE   = 3'd1,
    KIND_TAG_END     = 3'd2,
    KIND_STOP_FRAME  = 3'd3,
    KIND_BAD_HEADER  = 3'd4
  } kind_e;

  // Parse phases
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_TAGHDR   = 2'd1,
    PH_FRAMEHDR = 2'd2,
    PH_TEXT     = 2'd3
  } phase_e;

  // Register indexes (paddr[2])
  typedef enum logic {
    REG_STOP_FRAME_ID = 1'b0,
    REG_MAJOR_VERSION = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } id3w_in_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] frame_id;
    logic [31:0] text_length;
    logic [7:0]  text_value;
    logic        frame_last;
    logic        tag_done;
  } id3w_out_t;

  typedef struct packed {
    logic [31:0] stop_frame_id;
    logic [7:0]  expected_major_version;
  } id3w_cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [27:0] tag_size;
    logic [27:0] tag_consumed;
  } id3w_stat_t;

  // Signature byte "ID3" at tag header position i
  function automatic logic [7:0] sig_byte(input logic [1:0] i);
    logic [7:0] v;
    case (i)
      2'd0:    v = 8'h49;
      2'd1:    v = 8'h44;
      2'd2:    v = 8'h33;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

>>> sv/id3w_cfg_regs.sv
// ----------------------------------------------------------------------------
// id3w_cfg_regs: configuration registers
// APB-style write and read of the stop frame id and the expected major version.
// ----------------------------------------------------------------------------
module id3w_cfg_regs import id3w_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output id3w_cfg_t          cfg_o
);

  logic      wr_en;
  reg_idx_e  reg_idx;
  id3w_cfg_t cfg_q, cfg_d;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_STOP_FRAME_ID: cfg_d.stop_frame_id          = pwdata;
        REG_MAJOR_VERSION: cfg_d.expected_major_version = pwdata[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_frame_id          <= STOP_ID_RESET;
      cfg_q.expected_major_version <= MAJOR_VER_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_STOP_FRAME_ID: prdata = cfg_q.stop_frame_id;
      REG_MAJOR_VERSION: prdata = {24'd0, cfg_q.expected_major_version};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/id3w_in_stage.sv
// ----------------------------------------------------------------------------
// id3w_in_stage: input register
// Captures one file byte and holds it until the walker steps on it.
// ----------------------------------------------------------------------------
module id3w_in_stage import id3w_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  id3w_in_t in_data_i,
  input  logic     step_i,
  output logic     s1_valid_o,
  output id3w_in_t s1_data_o
);

  logic     valid_q, valid_d;
  id3w_in_t data_q, data_d;
  logic     load;

  // Free when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || step_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = in_data_i;
    end else if (step_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign s1_valid_o = valid_q;
  assign s1_data_o  = data_q;

endmodule

>>> sv/id3w_walker.sv
// ----------------------------------------------------------------------------
// id3w_walker: tag header check and frame walk
// Holds the parse state and works out the result of one byte per step.
// ----------------------------------------------------------------------------
module id3w_walker import id3w_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  id3w_in_t   item_i,
  input  id3w_cfg_t  cfg_i,
  output logic       res_valid_o,
  output id3w_out_t  res_o,
  output id3w_stat_t stat_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [27:0] size_q, size_d;
  logic [27:0] cons_q, cons_d;
  logic [63:0] shift_q, shift_d;
  logic [31:0] rem_q, rem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      size_q  <= '0;
      cons_q  <= '0;
      shift_q <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      size_q  <= size_d;
      cons_q  <= cons_d;
      shift_q <= shift_d;
      rem_q   <= rem_d;
    end
  end

  // Next state and result for the held byte
  always_comb begin
    logic [7:0]  b;
    phase_e      ph;
    logic [3:0]  idx;
    logic [27:0] tsize;
    logic [27:0] cons;
    logic [63:0] shift;
    logic [31:0] rem;
    logic        bad;
    logic [27:0] size_new;
    logic [27:0] cons_inc;
    logic        done;
    logic [63:0] shift_new;
    logic [31:0] len;
    logic [31:0] rem_new;

    b     = item_i.data_byte;
    ph    = phase_q;
    idx   = idx_q;
    tsize = size_q;
    cons  = cons_q;
    shift = shift_q;
    rem   = rem_q;

    // Restart on the first byte of a file
    if (item_i.first_byte) begin
      ph    = PH_TAGHDR;
      idx   = '0;
      tsize = '0;
      cons  = '0;
      shift = '0;
      rem   = '0;
    end

    phase_d     = ph;
    idx_d       = idx;
    size_d      = tsize;
    cons_d      = cons;
    shift_d     = shift;
    rem_d       = rem;
    res_valid_o = 1'b0;
    res_o       = '0;

    cons_inc  = cons + 28'd1;
    done      = (cons_inc >= tsize);
    shift_new = (idx < SHIFT_END_IDX) ? {shift[55:0], b} : shift;
    len       = shift_new[31:0] - 32'd1;
    rem_new   = (rem != 32'd0) ? (rem - 32'd1) : rem;
    bad       = ((idx < VER_IDX) && (b != sig_byte(idx[1:0]))) ||
                ((idx == VER_IDX) && (b != cfg_i.expected_major_version)) ||
                ((idx == REV_IDX) && (b != REV_BYTE));
    size_new  = (idx >= SIZE_FIRST_IDX) ? {tsize[20:0], b[6:0]} : tsize;

    case (ph)
      PH_TAGHDR: begin
        if (bad) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_BAD_HEADER;
          phase_d     = PH_IDLE;
        end else begin
          size_d = size_new;
          if (idx >= TAG_LAST_IDX) begin
            if (size_new == 28'd0) begin
              // Empty tag
              res_valid_o    = 1'b1;
              res_o.kind     = KIND_TAG_END;
              res_o.tag_done = 1'b1;
              phase_d        = PH_IDLE;
            end else begin
              phase_d = PH_FRAMEHDR;
              idx_d   = '0;
              shift_d = '0;
            end
          end else begin
            idx_d = idx + 4'd1;
          end
        end
      end

      PH_FRAMEHDR: begin
        cons_d  = cons_inc;
        shift_d = shift_new;
        if ((idx == ID_LAST_IDX) && (shift_new[31:0] == cfg_i.stop_frame_id)) begin
          // Stop frame id reached
          res_valid_o    = 1'b1;
          res_o.kind     = KIND_STOP_FRAME;
          res_o.frame_id = shift_new[31:0];
          res_o.tag_done = done;
          phase_d        = PH_IDLE;
        end else if ((idx == FSIZE_LAST_IDX) && (shift_new[31:0] == 32'd0)) begin
          // Zero-size frame is padding: end of tag
          res_valid_o    = 1'b1;
          res_o.kind     = KIND_TAG_END;
          res_o.frame_id = shift_new[63:32];
          res_o.tag_done = done;
          phase_d        = PH_IDLE;
        end else if (idx >= FRAME_LAST_IDX) begin
          // Encoding byte: announce the frame
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_FRAME_START;
          res_o.frame_id    = shift_new[63:32];
          res_o.text_length = len;
          res_o.frame_last  = (len == 32'd0);
          res_o.tag_done    = done;
          if (done) begin
            phase_d = PH_IDLE;
          end else if (len == 32'd0) begin
            idx_d   = '0;
            shift_d = '0;
          end else begin
            phase_d = PH_TEXT;
            rem_d   = len;
          end
        end else if (done) begin
          res_valid_o    = 1'b1;
          res_o.kind     = KIND_TAG_END;
          res_o.tag_done = 1'b1;
          phase_d        = PH_IDLE;
        end else begin
          idx_d = idx + 4'd1;
        end
      end

      PH_TEXT: begin
        cons_d           = cons_inc;
        rem_d            = rem_new;
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_TEXT_BYTE;
        res_o.text_value = b;
        res_o.frame_last = (rem_new == 32'd0);
        res_o.tag_done   = done;
        if (done) begin
          phase_d = PH_IDLE;
        end else if (rem_new == 32'd0) begin
          phase_d = PH_FRAMEHDR;
          idx_d   = '0;
          shift_d = '0;
        end
      end

      default: begin
        // Idle: drop the byte
        phase_d = PH_IDLE;
      end
    endcase
  end

  assign stat_o.phase        = phase_q;
  assign stat_o.tag_size     = size_q;
  assign stat_o.tag_consumed = cons_q;

endmodule

>>> sv/id3w_out_stage.sv
// ----------------------------------------------------------------------------
// id3w_out_stage: result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module id3w_out_stage import id3w_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic      res_valid_i,
  input  id3w_out_t res_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output id3w_out_t out_data_o
);

  logic      valid_q, valid_d;
  id3w_out_t data_q, data_d;

  // Room when empty or when the held result leaves this cycle
  assign room_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (step_i) begin
      valid_d = res_valid_i;
      data_d  = res_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> sv/id3_tag_frame_walker_top.sv
// ----------------------------------------------------------------------------
// id3_tag_frame_walker_top: ID3v2.3 tag frame walker
// Checks the tag header of a byte stream and reports frames and text bytes.
// ----------------------------------------------------------------------------
// The walker takes one file byte per cycle while the result register has room
// and gives at most one result item per byte; a byte flagged first_byte restarts
// the parse as tag header byte 0. A byte passes through the input register and
// then the result register. The rate is one item per cycle with both sides
// flowing; the only limit is the result register, which holds a result until it
// is taken, and a new byte is accepted in the same cycle the previous result
// leaves. The stop frame id and the expected major version are written through
// the APB port at byte addresses 0 and 4; the user must write them only while no
// item is in flight, which the block itself does not enforce; both read back.
module id3_tag_frame_walker_top import id3w_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  id3w_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output id3w_out_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  id3w_cfg_t  cfg;
  logic       s1_valid;
  id3w_in_t   s1_data;
  logic       room;
  logic       step;
  logic       res_valid;
  id3w_out_t  res;
  id3w_stat_t stat;

  // Step the walker when a byte is held and the result register has room
  assign step = s1_valid && room;

  id3w_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  id3w_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .step_i     (step),
    .s1_valid_o (s1_valid),
    .s1_data_o  (s1_data)
  );

  id3w_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (s1_data),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res),
    .stat_o      (stat)
  );

  id3w_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A held byte stays put while the result register is full
  a_hold_stalled_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !room) |=> (s1_valid && $stable(s1_data)))
    else $error("held byte lost or changed while stalled");

  // During the frame walk the consumed count stays below the tag size
  a_consumed_below_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((stat.phase == PH_FRAMEHDR) || (stat.phase == PH_TEXT)) |->
      (stat.tag_consumed < stat.tag_size))
    else $error("tag consumed count reached tag size during walk");

  // A result that uses up the tag ends the walk
  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_valid && res.tag_done) |=> (stat.phase == PH_IDLE))
    else $error("walk continued after tag size used up");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the ID3 tag frame walker
// Feeds byte streams built as ID3v2.3 tags (mostly well formed, some broken or
// noisy) under random idling on both sides, gets each result item from a model
// of the parse kept here or from the directed table, and compares field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import id3w_pkg::*;

  localparam int          ITEMS_PER_PHASE = 200;
  localparam int          NUM_PHASES      = 8;
  localparam int          DRAIN_CYCLES    = 8;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          PRINT_LIMIT     = 200;
  localparam logic [0:2][7:0] ID3_SIG     = {8'h49, 8'h44, 8'h33};  // "ID3"
  localparam id3w_out_t   NO_RESULT       = '0;

  // How an item's result is checked
  typedef enum logic [1:0] {
    CHK_MODEL,  // predicted
    CHK_QUIET,  // no result allowed
    CHK_GIVEN   // result typed in the table
  } check_e;

  typedef struct {
    id3w_in_t  item;
    check_e    chk;
    id3w_out_t given;
  } feed_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  id3w_in_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  id3w_out_t           out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  id3_tag_frame_walker_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Directed bytes: idle byte, bad first byte, then a tag of size 15 holding
  // an empty-text frame and the stop frame, which uses up the tag.
  feed_item_t dir_rows [27] = '{
    '{'{8'hFF, 1'b0}, CHK_QUIET, NO_RESULT},  // idle, ignored
    '{'{8'h00, 1'b1}, CHK_GIVEN, '{KIND_BAD_HEADER, 32'h0, 32'h0, 8'h0, 1'b0, 1'b0}},
    '{'{8'h49, 1'b1}, CHK_MODEL, NO_RESULT},
    '{'{8'h44, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h33, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h03, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h00, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'hFF, 1'b0}, CHK_MODEL, NO_RESULT},  // tag flags
    '{'{8'h80, 1'b0}, CHK_MODEL, NO_RESULT},  // size, top bits set
    '{'{8'h80, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h80, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h8F, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h54, 1'b0}, CHK_MODEL, NO_RESULT},  // "TIT2"
    '{'{8'h49, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h54, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h32, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h00, 1'b0}, CHK_MODEL, NO_RESULT},  // frame size 1
    '{'{8'h00, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h00, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h01, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'hFF, 1'b0}, CHK_MODEL, NO_RESULT},  // frame flags
    '{'{8'h00, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h00, 1'b0}, CHK_GIVEN,
      '{KIND_FRAME_START, 32'h5449_5432, 32'h0, 8'h0, 1'b1, 1'b0}},
    '{'{8'h41, 1'b0}, CHK_MODEL, NO_RESULT},  // "APIC"
    '{'{8'h50, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h49, 1'b0}, CHK_MODEL, NO_RESULT},
    '{'{8'h43, 1'b0}, CHK_GIVEN,
      '{KIND_STOP_FRAME, 32'h4150_4943, 32'h0, 8'h0, 1'b0, 1'b1}}
  };

  feed_item_t  byte_feed_q [$];
  id3w_out_t   walk_results_q [$];
  feed_item_t  cur_item;
  logic        in_took;
  int unsigned feed_gap;
  bit          in_idle_on;
  bit          out_idle_on;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned stall_left;
  int          mismatches;
  int          walk_items;
  int          results_seen;

  // Predictor copy of the walker's registers and state
  logic [31:0] cfg_stop;
  logic [7:0]  cfg_major;
  phase_e      walk_phase;
  int          hdr_pos;
  logic [27:0] tag_size;
  logic [31:0] tag_used;
  logic [63:0] fhdr_shift;
  logic [31:0] text_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t: %s mismatch, got %h, want %h (result %0d)", $realtime, what, got,
               want, results_seen);
    mismatches++;
  endtask

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the parse by one byte and work out its result item, if any
  task automatic walk_predict(input id3w_in_t it, output logic has, output id3w_out_t res);
    logic [7:0]  b;
    logic        done;
    logic [31:0] len;
    b = it.data_byte;
    has = 1'b0;
    res = '0;
    if (it.first_byte) begin
      walk_phase = PH_TAGHDR;
      hdr_pos    = 0;
      tag_size   = '0;
      tag_used   = '0;
      fhdr_shift = '0;
      text_left  = '0;
    end
    case (walk_phase)
      PH_TAGHDR: begin
        if ((hdr_pos < 3 && b != ID3_SIG[hdr_pos]) || (hdr_pos == 3 && b != cfg_major) ||
            (hdr_pos == 4 && b != 8'h00)) begin
          has = 1'b1;
          res.kind = KIND_BAD_HEADER;
          walk_phase = PH_IDLE;
        end else begin
          // syncsafe size: seven bits per byte
          if (hdr_pos >= 6) tag_size = {tag_size[20:0], b[6:0]};
          if (hdr_pos == 9) begin
            if (tag_size == 0) begin
              has = 1'b1;
              res.kind = KIND_TAG_END;
              res.tag_done = 1'b1;
              walk_phase = PH_IDLE;
            end else begin
              walk_phase = PH_FRAMEHDR;
              hdr_pos = 0;
              fhdr_shift = '0;
            end
          end else begin
            hdr_pos++;
          end
        end
      end
      PH_FRAMEHDR: begin
        tag_used++;
        done = (tag_used >= {4'h0, tag_size});
        if (hdr_pos < 8) fhdr_shift = {fhdr_shift[55:0], b};
        if (hdr_pos == 3 && fhdr_shift[31:0] == cfg_stop) begin
          has = 1'b1;
          res.kind = KIND_STOP_FRAME;
          res.frame_id = fhdr_shift[31:0];
          res.tag_done = done;
          walk_phase = PH_IDLE;
        end else if (hdr_pos == 7 && fhdr_shift[31:0] == 0) begin
          // zero-size frame is padding: end of tag
          has = 1'b1;
          res.kind = KIND_TAG_END;
          res.frame_id = fhdr_shift[63:32];
          res.tag_done = done;
          walk_phase = PH_IDLE;
        end else if (hdr_pos >= 10) begin
          len = fhdr_shift[31:0] - 32'd1;
          has = 1'b1;
          res.kind = KIND_FRAME_START;
          res.frame_id = fhdr_shift[63:32];
          res.text_length = len;
          res.frame_last = (len == 0);
          res.tag_done = done;
          if (done) begin
            walk_phase = PH_IDLE;
          end else if (len == 0) begin
            hdr_pos = 0;
            fhdr_shift = '0;
          end else begin
            walk_phase = PH_TEXT;
            text_left = len;
          end
        end else if (done) begin
          has = 1'b1;
          res.kind = KIND_TAG_END;
          res.tag_done = 1'b1;
          walk_phase = PH_IDLE;
        end else begin
          hdr_pos++;
        end
      end
      PH_TEXT: begin
        tag_used++;
        done = (tag_used >= {4'h0, tag_size});
        if (text_left != 0) text_left--;
        has = 1'b1;
        res.kind = KIND_TEXT_BYTE;
        res.text_value = b;
        res.frame_last = (text_left == 0);
        res.tag_done = done;
        if (done) begin
          walk_phase = PH_IDLE;
        end else if (text_left == 0) begin
          walk_phase = PH_FRAMEHDR;
          hdr_pos = 0;
          fhdr_shift = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic first);
    feed_item_t f;
    f.item.data_byte  = b;
    f.item.first_byte = first;
    f.chk   = CHK_MODEL;
    f.given = NO_RESULT;
    byte_feed_q.push_back(f);
  endtask

  // Build one file: mostly a tag with random frames, sometimes noise or a
  // broken header. Tag size lands on, before or past the end of the frames.
  task automatic gen_file();
    logic [7:0]  frame_bytes [$];
    logic [7:0]  hv [5];
    logic [7:0]  sb;
    logic [31:0] fid;
    logic [31:0] fsize;
    logic [31:0] tsize;
    int          bad_pos;
    int          ntext;
    int          nf;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      nf = $urandom_range(1, 12);
      for (int i = 0; i < nf; i++)
        push_byte(8'($urandom_range(0, 255)),
                  (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0));
      return;
    end
    hv = '{8'h49, 8'h44, 8'h33, cfg_major, 8'h00};
    bad_pos = -1;
    if ($urandom_range(0, 99) < 15) begin
      bad_pos = $urandom_range(0, 4);
      hv[bad_pos] = hv[bad_pos] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < 5; i++) push_byte(hv[i], i == 0);
    if (bad_pos >= 0) begin
      nf = $urandom_range(0, 3);
      for (int i = 0; i < nf; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
      return;
    end
    // frames
    nf = $urandom_range(0, 4);
    for (int i = 0; i < nf; i++) begin
      fid = ($urandom_range(0, 5) == 0) ? cfg_stop : $urandom;
      r = $urandom_range(0, 99);
      if (r < 8) fsize = 0;
      else if (r < 30) fsize = 1;
      else if (r < 90) fsize = $urandom_range(2, 9);
      else if (r < 95) fsize = 32'hFFFF_FFFF;
      else fsize = $urandom;
      if (fsize == 0) ntext = 0;
      else if (fsize - 1 > 9) ntext = $urandom_range(0, 9);
      else ntext = fsize - 1;
      for (int k = 3; k >= 0; k--) frame_bytes.push_back(fid[8*k +: 8]);
      for (int k = 3; k >= 0; k--) frame_bytes.push_back(fsize[8*k +: 8]);
      for (int k = 0; k < 3 + ntext; k++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    r = $urandom_range(0, 99);
    if (r < 55) tsize = frame_bytes.size();
    else if (r < 75) tsize = (frame_bytes.size() == 0) ? 0 :
                             $urandom_range(0, frame_bytes.size() - 1);
    else if (r < 88) tsize = frame_bytes.size() + $urandom_range(1, 30);
    else if (r < 94) tsize = 0;
    else tsize = 32'h0FFF_FFFF;
    push_byte(8'($urandom_range(0, 255)), 1'b0);  // tag flags
    for (int k = 0; k < 4; k++) begin
      sb = 8'(tsize >> (7 * (3 - k)));
      sb[7] = 1'($urandom_range(0, 1));
      push_byte(sb, 1'b0);
    end
    foreach (frame_bytes[i]) push_byte(frame_bytes[i], 1'b0);
    // trailing bytes after the walk are ignored
    if ($urandom_range(0, 3) == 0) begin
      nf = $urandom_range(1, 4);
      for (int i = 0; i < nf; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Offer bytes at the falling edge, with random gaps
  always @(negedge clk_i) begin : feed_drive
    logic nxt_valid;
    if (rst_ni && (!in_valid_i || in_took)) begin
      nxt_valid = 1'b0;
      if (feed_gap != 0) begin
        feed_gap--;
      end else if (byte_feed_q.size() != 0) begin
        cur_item = byte_feed_q.pop_front();
        in_data_i <= cur_item.item;
        nxt_valid = 1'b1;
        feed_gap = in_idle_on ? pick_gap() : 0;
      end
      in_valid_i <= nxt_valid;
    end
  end

  // Result ready: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin : ready_drive
    if (rst_ni) begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Predict on each accepted byte; check each accepted result
  always @(posedge clk_i) begin : walk_check
    logic      has;
    id3w_out_t res;
    id3w_out_t got;
    id3w_out_t want;
    in_took <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (walk_phase != PH_IDLE || in_data_i.first_byte) walk_items++;
      walk_predict(in_data_i, has, res);
      case (cur_item.chk)
        CHK_MODEL: if (has) walk_results_q.push_back(res);
        CHK_GIVEN: walk_results_q.push_back(cur_item.given);
        default: ;
      endcase
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      results_seen++;
      if (walk_results_q.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(got.kind), 32'h0);
      end else begin
        want = walk_results_q.pop_front();
        if (got.kind !== want.kind)
          report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.frame_id !== want.frame_id)
          report_mismatch("frame_id", got.frame_id, want.frame_id);
        if (got.text_length !== want.text_length)
          report_mismatch("text_length", got.text_length, want.text_length);
        if (got.text_value !== want.text_value)
          report_mismatch("text_value", 32'(got.text_value), 32'(want.text_value));
        if (got.frame_last !== want.frame_last)
          report_mismatch("frame_last", 32'(got.frame_last), 32'(want.frame_last));
        if (got.tag_done !== want.tag_done)
          report_mismatch("tag_done", 32'(got.tag_done), 32'(want.tag_done));
      end
    end
  end

  task automatic apb_write(input reg_idx_e ri, input logic [PDATA_W-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ri, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input reg_idx_e ri, output logic [PDATA_W-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {ri, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    v = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write both registers, read them back, and track them in the predictor
  task automatic set_walk_config(input logic [31:0] stop_id, input logic [7:0] major);
    logic [PDATA_W-1:0] rd;
    apb_write(REG_STOP_FRAME_ID, stop_id);
    apb_write(REG_MAJOR_VERSION, {24'h0, major});
    apb_read(REG_STOP_FRAME_ID, rd);
    if (rd !== stop_id) report_mismatch("stop_frame_id readback", rd, stop_id);
    apb_read(REG_MAJOR_VERSION, rd);
    if (rd !== {24'h0, major}) report_mismatch("major version readback", rd, {24'h0, major});
    cfg_stop  = stop_id;
    cfg_major = major;
  endtask

  // Wait until every byte is taken and every result has come, then settle
  task automatic drain_walker();
    while (byte_feed_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (walk_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : main_seq
    logic [PDATA_W-1:0] rd;
    int                 phase_start;
    bit                 pressed;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_took     = 1'b0;
    feed_gap    = 0;
    hold_req    = 1'b0;
    hold_left   = 0;
    stall_left  = 0;
    mismatches  = 0;
    walk_items  = 0;
    results_seen = 0;
    cfg_stop    = 32'h4150_4943;
    cfg_major   = 8'd3;
    walk_phase  = PH_IDLE;
    hdr_pos     = 0;
    tag_size    = '0;
    tag_used    = '0;
    fhdr_shift  = '0;
    text_left   = '0;
    pressed     = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // registers come out of reset as APIC and version 3
    apb_read(REG_STOP_FRAME_ID, rd);
    if (rd !== 32'h4150_4943) report_mismatch("stop_frame_id reset", rd, 32'h4150_4943);
    apb_read(REG_MAJOR_VERSION, rd);
    if (rd !== 32'h3) report_mismatch("major version reset", rd, 32'h3);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: set_walk_config(32'h0000_0000, 8'h00);
        2: set_walk_config(32'hFFFF_FFFF, 8'hFF);
        3: set_walk_config($urandom, 8'($urandom_range(0, 255)));
        4: set_walk_config(32'h5449_5432, 8'd4);
        5: set_walk_config($urandom, 8'd3);
        6: set_walk_config(32'h4150_4943, 8'd3);
        7: set_walk_config($urandom, 8'($urandom_range(0, 255)));
        default: ;
      endcase
      case (p)
        0, 1: begin
          in_idle_on  = 1'b1;
          out_idle_on = 1'b1;
        end
        2: begin
          in_idle_on  = 1'b0;
          out_idle_on = 1'b1;
        end
        3: begin
          in_idle_on  = 1'b0;
          out_idle_on = 1'b0;
        end
        default: begin
          in_idle_on  = ($urandom_range(0, 3) != 0);
          out_idle_on = ($urandom_range(0, 3) != 0);
        end
      endcase
      if (p == 0) foreach (dir_rows[i]) byte_feed_q.push_back(dir_rows[i]);
      phase_start = walk_items;
      while (walk_items - phase_start < ITEMS_PER_PHASE) begin
        // hold results off once while bytes keep coming
        if (p == 2 && !pressed && walk_items - phase_start >= 40) begin
          hold_req = 1'b1;
          pressed  = 1'b1;
        end
        if (byte_feed_q.size() < 16) gen_file();
        else @(posedge clk_i);
      end
      drain_walker();
    end

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
